[rtl/dbot_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// Shared constants, codes and types of the depth-bucket ordering table.
// Used by the interfaces, controller, datapath and top level; depends on nothing.
package dbot_pkg;

   localparam int Z_BUCKETS    = 256;
   localparam int POOL_ENTRIES = 1024;

   localparam int BUCKET_W = $clog2(Z_BUCKETS);
   localparam int ENTRY_W  = $clog2(POOL_ENTRIES);
   localparam int COUNT_W  = $clog2(POOL_ENTRIES + 1);
   localparam int HANDLE_W = 32;
   localparam int DEPTH_W  = 32;

   localparam logic [BUCKET_W-1:0]       BUCKET_TOP       = BUCKET_W'(Z_BUCKETS - 1);
   localparam logic signed [DEPTH_W-1:0] BUCKET_TOP_DEPTH = DEPTH_W'(Z_BUCKETS - 1);
   localparam logic [COUNT_W-1:0]        POOL_LIMIT       = COUNT_W'(POOL_ENTRIES);

   typedef enum logic [1:0] {
      ACT_CLEAR  = 2'd0,
      ACT_ADD    = 2'd1,
      ACT_REWIND = 2'd2,
      ACT_NEXT   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_FULL = 2'd1,
      ST_END  = 2'd2
   } status_type;

   typedef struct packed {
      logic                link_valid;
      logic [ENTRY_W-1:0]  link;
      logic [HANDLE_W-1:0] handle;
   } entry_type;

   typedef struct packed {
      logic capture;
      logic clear;
      logic rewind;
      logic add_rd;
      logic add_wr;
      logic set_full;
      logic scan_step;
      logic head_fwd;
      logic entry_take;
      logic set_end;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic pool_full;
      logic cursor_valid;
      logic cursor_done;
      logic bucket_live;
      logic out_free;
   } stat_type;

endpackage
`default_nettype wire

[rtl/dbot_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// Request and response channel interfaces of the ordering table.
// Depend on dbot_pkg for field widths.
interface dbot_req_if
   import dbot_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [1:0]          action;
   logic [HANDLE_W-1:0] packet_handle;
   logic [DEPTH_W-1:0]  depth;

   modport source (output valid, action, packet_handle, depth, input ready);
   modport sink   (input valid, action, packet_handle, depth, output ready);
endinterface

interface dbot_rsp_if
   import dbot_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [HANDLE_W-1:0] packet_out;
   logic [1:0]          status;

   modport source (output valid, packet_out, status, input ready);
   modport sink   (input valid, packet_out, status, output ready);
endinterface
`default_nettype wire

[rtl/dbot_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// Generic single-write, single-read RAM with a registered read port.
// Self-contained; used for the bucket heads and the entry pool.
module dbot_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[rtl/dbot_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// Sequencing state machine of the ordering table.
// Depends on dbot_pkg; drives the datapath through cmd_type and reads stat_type.
module dbot_ctrl
   import dbot_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic [1:0] req_action,
   output logic            req_ready,
   input  wire stat_type   stat,
   output cmd_type         cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_CLEAR,
      S_REWIND,
      S_ADD_RD,
      S_ADD_WR,
      S_NEXT,
      S_SCAN,
      S_HEAD_WAIT,
      S_ENTRY_WAIT,
      S_RESP
   } state_type;

   state_type  state_ff;
   state_type  state_in;
   action_type action;

   assign action    = action_type'(req_action);
   assign req_ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               unique case (action)
                  ACT_CLEAR:  state_in = S_CLEAR;
                  ACT_ADD:    state_in = S_ADD_RD;
                  ACT_REWIND: state_in = S_REWIND;
                  ACT_NEXT:   state_in = S_NEXT;
                  default:    state_in = S_IDLE;
               endcase
            end
         end
         S_CLEAR: begin
            cmd.clear = 1'b1;
            state_in  = S_RESP;
         end
         S_REWIND: begin
            cmd.rewind = 1'b1;
            state_in   = S_RESP;
         end
         S_ADD_RD: begin
            if (stat.pool_full) begin
               cmd.set_full = 1'b1;
               state_in     = S_RESP;
            end else begin
               cmd.add_rd = 1'b1;
               state_in   = S_ADD_WR;
            end
         end
         S_ADD_WR: begin
            cmd.add_wr = 1'b1;
            state_in   = S_RESP;
         end
         S_NEXT: begin
            if (stat.cursor_valid) begin
               state_in = S_ENTRY_WAIT;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (stat.cursor_done) begin
               cmd.set_end = 1'b1;
               state_in    = S_RESP;
            end else begin
               cmd.scan_step = 1'b1;
               if (stat.bucket_live) begin
                  state_in = S_HEAD_WAIT;
               end
            end
         end
         S_HEAD_WAIT: begin
            cmd.head_fwd = 1'b1;
            state_in     = S_ENTRY_WAIT;
         end
         S_ENTRY_WAIT: begin
            cmd.entry_take = 1'b1;
            state_in       = S_RESP;
         end
         S_RESP: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule
`default_nettype wire

[rtl/dbot_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// Datapath of the ordering table: head and entry memories, cursor, pool count
// and output register. Depends on dbot_pkg and dbot_ram.
module dbot_datapath
   import dbot_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cmd_type             cmd,
   output stat_type                 stat,
   input  wire logic [HANDLE_W-1:0] req_packet_handle,
   input  wire logic [DEPTH_W-1:0]  req_depth,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [HANDLE_W-1:0]      rsp_packet_out,
   output logic [1:0]               rsp_status
);

   logic [HANDLE_W-1:0] handle_ff;
   logic [BUCKET_W-1:0] bucket_ff;
   logic [BUCKET_W-1:0] bucket_in;
   logic [Z_BUCKETS-1:0] head_valid_ff;
   logic [COUNT_W-1:0]  free_count_ff;
   logic [BUCKET_W-1:0] cursor_bucket_ff;
   logic                cursor_done_ff;
   logic [ENTRY_W-1:0]  cursor_entry_ff;
   logic                cursor_valid_ff;
   logic [HANDLE_W-1:0] res_pkt_ff;
   status_type          res_status_ff;
   logic                rsp_valid_ff;
   logic [HANDLE_W-1:0] rsp_pkt_ff;
   status_type          rsp_status_ff;

   logic [BUCKET_W-1:0] head_rd_addr;
   logic [ENTRY_W-1:0]  head_rd_data;
   logic [ENTRY_W-1:0]  entry_rd_addr;
   logic [ENTRY_W-1:0]  new_entry;
   entry_type           entry_wr_data;
   entry_type           entry_rd_data;

   always_comb begin
      if (req_depth[DEPTH_W-1]) begin
         bucket_in = '0;
      end else if ($signed(req_depth) > BUCKET_TOP_DEPTH) begin
         bucket_in = BUCKET_TOP;
      end else begin
         bucket_in = req_depth[BUCKET_W-1:0];
      end
   end

   assign new_entry     = free_count_ff[ENTRY_W-1:0];
   assign head_rd_addr  = cmd.add_rd ? bucket_ff : cursor_bucket_ff;
   assign entry_rd_addr = cmd.head_fwd ? head_rd_data : cursor_entry_ff;

   always_comb begin
      entry_wr_data.handle     = handle_ff;
      entry_wr_data.link       = head_rd_data;
      entry_wr_data.link_valid = head_valid_ff[bucket_ff];
   end

   dbot_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(Z_BUCKETS)
   ) u_head_ram (
      .clock  (clock),
      .wr_en  (cmd.add_wr),
      .wr_addr(bucket_ff),
      .wr_data(new_entry),
      .rd_addr(head_rd_addr),
      .rd_data(head_rd_data)
   );

   dbot_ram #(
      .WIDTH($bits(entry_type)),
      .DEPTH(POOL_ENTRIES)
   ) u_entry_ram (
      .clock  (clock),
      .wr_en  (cmd.add_wr),
      .wr_addr(new_entry),
      .wr_data(entry_wr_data),
      .rd_addr(entry_rd_addr),
      .rd_data(entry_rd_data)
   );

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         handle_ff <= req_packet_handle;
         bucket_ff <= bucket_in;
      end
      if (cmd.clear || cmd.rewind || cmd.add_wr) begin
         res_pkt_ff    <= '0;
         res_status_ff <= ST_OK;
      end else if (cmd.set_full) begin
         res_pkt_ff    <= '0;
         res_status_ff <= ST_FULL;
      end else if (cmd.set_end) begin
         res_pkt_ff    <= '0;
         res_status_ff <= ST_END;
      end else if (cmd.entry_take) begin
         res_pkt_ff    <= entry_rd_data.handle;
         res_status_ff <= ST_OK;
      end
      if (cmd.out_load) begin
         rsp_pkt_ff    <= res_pkt_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         head_valid_ff    <= '0;
         free_count_ff    <= '0;
         cursor_bucket_ff <= BUCKET_TOP;
         cursor_done_ff   <= 1'b0;
         cursor_valid_ff  <= 1'b0;
      end else begin
         if (cmd.add_wr) begin
            head_valid_ff[bucket_ff] <= 1'b1;
            free_count_ff            <= free_count_ff + COUNT_W'(1);
         end
         if (cmd.rewind) begin
            cursor_bucket_ff <= BUCKET_TOP;
            cursor_done_ff   <= 1'b0;
            cursor_valid_ff  <= 1'b0;
         end else if (cmd.scan_step) begin
            if (cursor_bucket_ff == '0) begin
               cursor_done_ff <= 1'b1;
            end else begin
               cursor_bucket_ff <= cursor_bucket_ff - BUCKET_W'(1);
            end
         end else if (cmd.set_end) begin
            cursor_valid_ff <= 1'b0;
         end else if (cmd.entry_take) begin
            cursor_entry_ff <= entry_rd_data.link;
            cursor_valid_ff <= entry_rd_data.link_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_comb begin
      stat.pool_full    = (free_count_ff == POOL_LIMIT);
      stat.cursor_valid = cursor_valid_ff;
      stat.cursor_done  = cursor_done_ff;
      stat.bucket_live  = head_valid_ff[cursor_bucket_ff];
      stat.out_free     = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_packet_out = rsp_pkt_ff;
   assign rsp_status     = rsp_status_ff;

endmodule
`default_nettype wire

[rtl/depth_bucket_ordering_table.sv]
`timescale 1ns / 1ps
`default_nettype none
// Depth-bucket ordering table: top level joining the controller and datapath.
// Depends on dbot_pkg, dbot_if, dbot_ctrl and dbot_datapath.
//
// Each request beat carries an action (clear, add, rewind or fetch next), a
// packet handle and a signed depth; each request gives exactly one response
// beat with a packet handle and a status (ok, pool full, or no more entries).
// Adds link the handle at the head of the bucket chosen by the clamped depth;
// fetches walk the buckets from the top down, newest entry first.
// One request is worked on at a time. Clear and rewind go straight to the
// response; an add reads the bucket head and then writes the entry and the
// new head, unless the pool is full; a fetch follows the current chain, or
// first searches for the next non-empty bucket and reads its head and entry.
// The search examines one bucket per cycle through the valid flags, and a
// found bucket's first entry reads both memories, later ones the entry memory.
// The next request is accepted as soon as the result has entered the output
// register; if the receiver stalls with a beat still held there, the block
// finishes the following request and then waits with its result.
// Reset empties every bucket and the pool and puts the read cursor at the top
// bucket; no clearing pass is needed, so requests are taken straight away.
module depth_bucket_ordering_table
   import dbot_pkg::*;
(
   input wire logic  clock,
   input wire logic  reset,
   dbot_req_if.sink  req_chan,
   dbot_rsp_if.source rsp_chan
);

   cmd_type  cmd;
   stat_type stat;

   dbot_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_action(req_chan.action),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   dbot_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_packet_handle(req_chan.packet_handle),
      .req_depth        (req_chan.depth),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_packet_out   (rsp_chan.packet_out),
      .rsp_status       (rsp_chan.status)
   );

endmodule
`default_nettype wire
